/* src/utf8_sequence_decoder_core_assert.svh */
// assertion macros used by the checker file
`ifndef UTF8_SEQUENCE_DECODER_CORE_ASSERT_SVH
`define UTF8_SEQUENCE_DECODER_CORE_ASSERT_SVH

// same-cycle implication
`define UTF8D_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define UTF8D_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/utf8d_pkg.sv */
// shared constants and types of the utf-8 sequence decoder
package utf8d_pkg;

	localparam int unsigned MAX_SEQ_BYTES = 6;
	localparam int unsigned LEN_W = 3;
	localparam int unsigned CP_W = 21;

	localparam logic [CP_W-1:0] CP_MAX = 21'h10ffff;
	// upper ten bits of a surrogate code point (d800..dfff)
	localparam logic [9:0] SURR_HI = 10'h01b;

	localparam logic [CP_W-1:0] MIN_LEN2 = 21'h000080;
	localparam logic [CP_W-1:0] MIN_LEN3 = 21'h000800;
	localparam logic [CP_W-1:0] MIN_LEN4 = 21'h010000;

	// lead byte decode handed from the front stage
	typedef struct packed {
		logic [LEN_W-1:0] cls;  // sequence length, zero for an unknown lead
		logic             ok;   // enough bytes and all needed follow bytes are 10xxxxxx
	} front_t;

endpackage

/* src/utf8d_front.sv */
// lead byte classification and follow byte checks
module utf8d_front #(
	parameter int unsigned MAX_SEQ_BYTES = utf8d_pkg::MAX_SEQ_BYTES
) (
	input  logic [7:0]                     byte_0,
	input  logic [7:0]                     byte_1,
	input  logic [7:0]                     byte_2,
	input  logic [7:0]                     byte_3,
	input  logic [7:0]                     byte_4,
	input  logic [7:0]                     byte_5,
	input  logic [utf8d_pkg::LEN_W-1:0]    avail_count,
	output utf8d_pkg::front_t              front
);

	logic [utf8d_pkg::LEN_W-1:0] cls;
	logic [5:1]                  cont;
	logic                        cont_ok;

	always_comb begin
		if (!byte_0[7]) begin
			cls = 3'd1;
		end else if (byte_0[7:5] == 3'b110) begin
			cls = 3'd2;
		end else if (byte_0[7:4] == 4'b1110) begin
			cls = 3'd3;
		end else if (byte_0[7:3] == 5'b11110) begin
			cls = 3'd4;
		end else if (byte_0[7:2] == 6'b111110) begin
			cls = 3'd5;
		end else if (byte_0[7:1] == 7'b1111110) begin
			cls = 3'd6;
		end else begin
			cls = 3'd0;
		end
		if (32'(cls) > MAX_SEQ_BYTES) begin
			cls = 3'd0;
		end
	end

	assign cont = {byte_5[7:6] == 2'b10, byte_4[7:6] == 2'b10, byte_3[7:6] == 2'b10,
		byte_2[7:6] == 2'b10, byte_1[7:6] == 2'b10};

	always_comb begin
		cont_ok = 1'b1;
		for (int i = 1; i <= 5; i++) begin
			if ((3'(i) < cls) && !cont[i]) begin
				cont_ok = 1'b0;
			end
		end
	end

	// ascii needs no availability; a count of seven covers every length
	assign front.cls = cls;
	assign front.ok  = (cls != 3'd0) && cont_ok && ((cls == 3'd1) || (avail_count >= cls));

endmodule

/* src/utf8_sequence_decoder_core.sv */
// Decodes one UTF-8 sequence per transaction from a six-byte window into a
// code point, the number of bytes used and a valid flag (code point and length
// read zero on any error). The block is a three-stage pipeline: lead decode and
// follow-byte checks, payload assembly, then overlong/range/surrogate checks in
// the output register. It takes one window every cycle while in_ready is high;
// ready is the stall back-propagated through the three stage registers, so a
// stall holds every occupied stage without loss while empty stages still fill.
module utf8_sequence_decoder_core #(
	parameter int unsigned MAX_SEQ_BYTES = utf8d_pkg::MAX_SEQ_BYTES
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [7:0]                     byte_0,
	input  logic [7:0]                     byte_1,
	input  logic [7:0]                     byte_2,
	input  logic [7:0]                     byte_3,
	input  logic [7:0]                     byte_4,
	input  logic [7:0]                     byte_5,
	input  logic [utf8d_pkg::LEN_W-1:0]    avail_count,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [utf8d_pkg::CP_W-1:0]     code_point,
	output logic [utf8d_pkg::LEN_W-1:0]    seq_length,
	output logic                           valid_res
);

	utf8d_pkg::front_t front;

	logic adv_s1, adv_s2, adv_s3;

	// stage 1
	logic                          v_s1;
	utf8d_pkg::front_t             front_s1;
	logic [6:0]                    lead_s1;
	logic [5:0]                    f1_s1, f2_s1, f3_s1;

	// stage 2
	logic                          v_s2;
	logic [utf8d_pkg::LEN_W-1:0]   cls_s2;
	logic                          ok_s2;
	logic [utf8d_pkg::CP_W-1:0]    cp_s2;

	// stage 3 / output
	logic                          v_s3;
	logic [utf8d_pkg::CP_W-1:0]    cp_s3;
	logic [utf8d_pkg::LEN_W-1:0]   len_s3;
	logic                          ok_s3;

	logic [utf8d_pkg::CP_W-1:0]    cp_asm;
	logic                          ok_asm;
	logic                          bad_val;

	utf8d_front #(
		.MAX_SEQ_BYTES (MAX_SEQ_BYTES)
	) u_front (
		.byte_0      (byte_0),
		.byte_1      (byte_1),
		.byte_2      (byte_2),
		.byte_3      (byte_3),
		.byte_4      (byte_4),
		.byte_5      (byte_5),
		.avail_count (avail_count),
		.front       (front)
	);

	assign adv_s3   = !v_s3 || out_ready;
	assign adv_s2   = !v_s2 || adv_s3;
	assign adv_s1   = !v_s1 || adv_s2;
	assign in_ready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (adv_s1) v_s1 <= in_valid;
			if (adv_s2) v_s2 <= v_s1;
			if (adv_s3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && adv_s1) begin
			front_s1 <= front;
			lead_s1  <= byte_0[6:0];
			f1_s1    <= byte_1[5:0];
			f2_s1    <= byte_2[5:0];
			f3_s1    <= byte_3[5:0];
		end
	end

	// five- and six-byte forms always land above the scalar range
	always_comb begin
		ok_asm = front_s1.ok;
		case (front_s1.cls)
			3'd1:    cp_asm = {14'd0, lead_s1};
			3'd2:    cp_asm = {10'd0, lead_s1[4:0], f1_s1};
			3'd3:    cp_asm = {5'd0, lead_s1[3:0], f1_s1, f2_s1};
			3'd4:    cp_asm = {lead_s1[2:0], f1_s1, f2_s1, f3_s1};
			default: begin
				cp_asm = '0;
				ok_asm = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (v_s1 && adv_s2) begin
			cls_s2 <= front_s1.cls;
			ok_s2  <= ok_asm;
			cp_s2  <= cp_asm;
		end
	end

	// overlong, out of range and surrogate rejection
	always_comb begin
		case (cls_s2)
			3'd2:    bad_val = cp_s2 < utf8d_pkg::MIN_LEN2;
			3'd3:    bad_val = cp_s2 < utf8d_pkg::MIN_LEN3;
			3'd4:    bad_val = (cp_s2 < utf8d_pkg::MIN_LEN4) || (cp_s2 > utf8d_pkg::CP_MAX);
			default: bad_val = 1'b0;
		endcase
		if (cp_s2[20:11] == utf8d_pkg::SURR_HI) begin
			bad_val = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s2 && adv_s3) begin
			ok_s3  <= ok_s2 && !bad_val;
			cp_s3  <= (ok_s2 && !bad_val) ? cp_s2 : '0;
			len_s3 <= (ok_s2 && !bad_val) ? cls_s2 : '0;
		end
	end

	assign out_valid  = v_s3;
	assign code_point = cp_s3;
	assign seq_length = len_s3;
	assign valid_res  = ok_s3;

endmodule

/* src/utf8d_checker.sv */
// port-level checks of the decoder, bound to the top level
`include "utf8_sequence_decoder_core_assert.svh"

module utf8d_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           out_valid,
	input  logic                           out_ready,
	input  logic [utf8d_pkg::CP_W-1:0]     code_point,
	input  logic [utf8d_pkg::LEN_W-1:0]    seq_length,
	input  logic                           valid_res
);

	`UTF8D_ASSERT_IMPL(a_err_zero, clk, arst_n, out_valid && !valid_res, (code_point == '0) && (seq_length == '0), "error result not zeroed")
	`UTF8D_ASSERT_IMPL(a_ok_range, clk, arst_n, out_valid && valid_res, (seq_length != '0) && (seq_length <= 3'd4) && (code_point <= utf8d_pkg::CP_MAX), "valid result out of range")
	`UTF8D_ASSERT_IMPL(a_no_surr, clk, arst_n, out_valid && valid_res, code_point[20:11] != utf8d_pkg::SURR_HI, "surrogate reported valid")
	`UTF8D_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(code_point) && $stable(seq_length) && $stable(valid_res), "stalled result changed")

endmodule

bind utf8_sequence_decoder_core utf8d_checker u_utf8d_checker (.*);

/* bench/testbench.sv */
// self-checking testbench for the utf-8 sequence decoder core
`timescale 1ns / 100ps

module testbench;

	localparam int unsigned LIMIT_CYCLES = 400000;
	localparam int unsigned HOLD_CYCLES = 300;
	localparam int unsigned MAX_REPORTS = 10;
	localparam int unsigned RANDOM_ITEMS = 990;
	localparam int unsigned DRAIN_CYCLES = 8;

	typedef struct packed {
		logic [2:0]      avail;
		logic [5:0][7:0] b;
	} window_t;

	typedef struct packed {
		logic [utf8d_pkg::CP_W-1:0]  code_point;
		logic [utf8d_pkg::LEN_W-1:0] seq_length;
		logic                        valid_res;
	} decode_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic out_valid;
	logic out_ready;
	logic [utf8d_pkg::CP_W-1:0] code_point;
	logic [utf8d_pkg::LEN_W-1:0] seq_length;
	logic valid_res;
	window_t drive_w;

	decode_t pending_decodes[$];
	int unsigned mismatches;
	int unsigned cycles;
	bit steady;
	bit hold_out;
	int unsigned ready_wait;

	utf8_sequence_decoder_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.byte_0(drive_w.b[0]),
		.byte_1(drive_w.b[1]),
		.byte_2(drive_w.b[2]),
		.byte_3(drive_w.b[3]),
		.byte_4(drive_w.b[4]),
		.byte_5(drive_w.b[5]),
		.avail_count(drive_w.avail),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.code_point(code_point),
		.seq_length(seq_length),
		.valid_res(valid_res)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// expected decode of one window
	function automatic decode_t decode_utf8(input window_t w);
		decode_t res;
		logic [2:0] avail;
		int need;
		logic [31:0] cp;
		logic [31:0] floor_cp;
		bit ok;
		res = '0;
		avail = (w.avail == 3'd7) ? 3'd6 : w.avail;
		// five/six-byte forms always exceed the scalar range, other leads are invalid
		if (!w.b[0][7])
			need = 1;
		else if (w.b[0][7:5] == 3'b110)
			need = 2;
		else if (w.b[0][7:4] == 4'b1110)
			need = 3;
		else if (w.b[0][7:3] == 5'b11110)
			need = 4;
		else
			need = 0;
		if (need == 1) begin
			res.code_point = utf8d_pkg::CP_W'(w.b[0]);
			res.seq_length = utf8d_pkg::LEN_W'(1);
			res.valid_res = 1'b1;
		end else if (need != 0 && int'(avail) >= need) begin
			ok = 1'b1;
			cp = 32'(w.b[0] & (8'h7f >> need));
			for (int k = 1; k < need; k++) begin
				if (w.b[k][7:6] != 2'b10)
					ok = 1'b0;
				cp = (cp << 6) | 32'(w.b[k][5:0]);
			end
			case (need)
				2: floor_cp = 32'h80;
				3: floor_cp = 32'h800;
				default: floor_cp = 32'h10000;
			endcase
			if (cp < floor_cp || cp > 32'(utf8d_pkg::CP_MAX)
					|| (cp & 32'hfffff800) == 32'hd800)
				ok = 1'b0;
			if (ok) begin
				res.code_point = cp[utf8d_pkg::CP_W-1:0];
				res.seq_length = utf8d_pkg::LEN_W'(need);
				res.valid_res = 1'b1;
			end
		end
		return res;
	endfunction

	function automatic int unsigned idle_len();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 65)
			return 0;
		else if (r < 93)
			return $urandom_range(3, 1);
		return $urandom_range(40, 8);
	endfunction

	function automatic window_t make_window(input logic [7:0] b0, input logic [7:0] b1,
			input logic [7:0] b2, input logic [7:0] b3, input logic [7:0] b4,
			input logic [7:0] b5, input logic [2:0] avail);
		window_t w;
		w.b = {b5, b4, b3, b2, b1, b0};
		w.avail = avail;
		return w;
	endfunction

	// mostly well-formed sequences with random payload, some noise and broken ones
	function automatic window_t random_window();
		window_t w;
		int unsigned r;
		int unsigned n;
		r = $urandom_range(99);
		for (int k = 0; k < 6; k++)
			w.b[k] = {2'b10, 6'($urandom)};
		if (r < 8) begin
			w.b = 48'({$urandom, $urandom});
			w.avail = 3'($urandom_range(7));
			return w;
		end
		r = $urandom_range(99);
		if (r < 20) n = 1;
		else if (r < 45) n = 2;
		else if (r < 70) n = 3;
		else if (r < 92) n = 4;
		else if (r < 96) n = 5;
		else n = 6;
		case (n)
			1: w.b[0] = {1'b0, 7'($urandom)};
			2: w.b[0] = {3'b110, 5'($urandom)};
			3: w.b[0] = ($urandom_range(3) == 0) ? 8'hed : {4'b1110, 4'($urandom)};
			4: w.b[0] = ($urandom_range(1) == 0) ? 8'($urandom_range(8'hf4, 8'hf0))
				: {5'b11110, 3'($urandom)};
			5: w.b[0] = {6'b111110, 2'($urandom)};
			default: w.b[0] = {7'b1111110, 1'($urandom)};
		endcase
		// bytes past the sequence are don't-care
		for (int k = n; k < 6; k++)
			if (k > 0 && $urandom_range(1) == 0)
				w.b[k] = 8'($urandom);
		if ($urandom_range(99) < 85)
			w.avail = 3'($urandom_range(7, (n > 6) ? 6 : n));
		else
			w.avail = 3'($urandom_range(7));
		if ($urandom_range(99) < 10)
			w.b[$urandom_range(5, 1)] = 8'($urandom);
		return w;
	endfunction

	task automatic note_mismatch(input string what, input decode_t want, input decode_t got);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("mismatch at %0t: %s expected cp=%06h len=%0d ok=%0b got cp=%06h len=%0d ok=%0b",
				$time, what, want.code_point, want.seq_length, want.valid_res,
				got.code_point, got.seq_length, got.valid_res);
	endtask

	// result check first, then record the transaction accepted at this edge
	always @(posedge clk) begin
		decode_t got;
		decode_t want;
		if (out_valid && out_ready) begin
			got.code_point = code_point;
			got.seq_length = seq_length;
			got.valid_res = valid_res;
			if (pending_decodes.size() == 0) begin
				note_mismatch("result with none pending", '0, got);
			end else begin
				want = pending_decodes.pop_front();
				if (got.code_point !== want.code_point || got.seq_length !== want.seq_length
						|| got.valid_res !== want.valid_res)
					note_mismatch("decode", want, got);
			end
		end
		if (in_valid && in_ready)
			pending_decodes.push_back(decode_utf8(drive_w));
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// sink side: random stalls, plus a long hold-off on request
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_out) begin
				out_ready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_out = 1'b0;
			end
			if (ready_wait != 0) begin
				out_ready = 1'b0;
				ready_wait--;
			end else begin
				out_ready = 1'b1;
				if (!steady)
					ready_wait = idle_len();
			end
		end
	end

	// called just after a falling edge, returns just after the next one past acceptance
	task automatic send_window(input window_t w);
		int unsigned gap;
		gap = steady ? 0 : idle_len();
		if (gap != 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		drive_w = w;
		in_valid = 1'b1;
		do
			@(posedge clk);
		while (!in_ready);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		in_valid = 1'b0;
		while (pending_decodes.size() != 0)
			@(negedge clk);
	endtask

	task automatic test_ascii();
		send_window(make_window(8'h00, 8'hff, 8'h00, 8'hff, 8'h00, 8'hff, 3'd0));
		send_window(make_window(8'h7f, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 3'd1));
		send_window(make_window(8'h41, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 3'd7));
	endtask

	task automatic test_multibyte();
		send_window(make_window(8'hc2, 8'h80, 8'hff, 8'h00, 8'hff, 8'h00, 3'd2));
		send_window(make_window(8'hdf, 8'hbf, 8'h00, 8'h00, 8'h00, 8'h00, 3'd6));
		send_window(make_window(8'he0, 8'ha0, 8'h80, 8'h00, 8'h00, 8'h00, 3'd3));
		send_window(make_window(8'hed, 8'h9f, 8'hbf, 8'h00, 8'h00, 8'h00, 3'd3));
		send_window(make_window(8'hee, 8'h80, 8'h80, 8'h00, 8'h00, 8'h00, 3'd4));
		send_window(make_window(8'hef, 8'hbf, 8'hbf, 8'hff, 8'hff, 8'hff, 3'd5));
		send_window(make_window(8'hf0, 8'h90, 8'h80, 8'h80, 8'h00, 8'h00, 3'd4));
		send_window(make_window(8'hf4, 8'h8f, 8'hbf, 8'hbf, 8'h00, 8'h00, 3'd7));
	endtask

	task automatic test_malformed();
		// overlong forms
		send_window(make_window(8'hc1, 8'hbf, 8'h00, 8'h00, 8'h00, 8'h00, 3'd2));
		send_window(make_window(8'he0, 8'h9f, 8'hbf, 8'h00, 8'h00, 8'h00, 3'd3));
		send_window(make_window(8'hf0, 8'h8f, 8'hbf, 8'hbf, 8'h00, 8'h00, 3'd4));
		// surrogate and beyond the scalar range
		send_window(make_window(8'hed, 8'ha0, 8'h80, 8'h00, 8'h00, 8'h00, 3'd3));
		send_window(make_window(8'hf4, 8'h90, 8'h80, 8'h80, 8'h00, 8'h00, 3'd4));
		send_window(make_window(8'hf7, 8'hbf, 8'hbf, 8'hbf, 8'h00, 8'h00, 3'd6));
		// five- and six-byte leads, and leads of no class
		send_window(make_window(8'hf8, 8'h88, 8'h80, 8'h80, 8'h80, 8'h00, 3'd5));
		send_window(make_window(8'hfc, 8'h84, 8'h80, 8'h80, 8'h80, 8'h80, 3'd6));
		send_window(make_window(8'hfe, 8'hbf, 8'hbf, 8'hbf, 8'hbf, 8'hbf, 3'd7));
		send_window(make_window(8'hff, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 3'd6));
		send_window(make_window(8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 3'd6));
		// truncated windows and a bad follow byte
		send_window(make_window(8'he2, 8'h82, 8'hac, 8'h00, 8'h00, 8'h00, 3'd2));
		send_window(make_window(8'he2, 8'hc2, 8'hac, 8'h00, 8'h00, 8'h00, 3'd3));
		send_window(make_window(8'hc3, 8'ha9, 8'h00, 8'h00, 8'h00, 8'h00, 3'd0));
	endtask

	// sink stalls long while the source keeps offering back-to-back windows
	task automatic test_backpressure();
		steady = 1'b1;
		hold_out = 1'b1;
		repeat (30)
			send_window(random_window());
		steady = 1'b0;
		wait_drained();
	endtask

	task automatic test_drain_pause();
		repeat (10)
			send_window(random_window());
		wait_drained();
		repeat (5) @(negedge clk);
	endtask

	task automatic test_random();
		for (int unsigned i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % 100 == 0)
				steady = ($urandom_range(3) == 0);
			send_window(random_window());
		end
		steady = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		drive_w = '0;
		mismatches = 0;
		cycles = 0;
		steady = 1'b0;
		hold_out = 1'b0;
		ready_wait = 0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_ascii();
		test_multibyte();
		test_malformed();
		test_backpressure();
		test_drain_pause();
		test_random();
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_decodes.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

/* files.f */
+incdir+src
src/utf8d_pkg.sv
src/utf8d_front.sv
src/utf8_sequence_decoder_core.sv
src/utf8d_checker.sv
bench/testbench.sv
